// ----- hdl/rdi_pkg.sv -----
`default_nettype none
package rdi_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 63;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_NORMAL_X = 3'd3,
        CFG_NORMAL_Y = 3'd4,
        CFG_NORMAL_Z = 3'd5,
        CFG_RADIUS_SQUARED = 3'd6
    } t_cfg_idx;

    localparam logic [30:0] DistMax = 31'h7FFF_FFFF;
    localparam logic signed [31:0] NormalZReset = 32'sd65536;
    localparam logic [62:0] RadiusSquaredReset = 63'h1_0000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic               is_hit;
        logic [30:0]        distance;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               flipped;
    } t_hit;

endpackage
`default_nettype wire

// ----- hdl/ray_disk_intersection.sv -----
`default_nettype none
// Ray / disk intersection test, fixed point.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one ray per item,
// origin and direction in signed Q16.16. Output channel (o_out_valid /
// i_out_stall / o_out_data): exactly one result item per ray, in order.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// disk center, normal and squared radius; write only while idle.
//
// Most of the pipe is the 31-stage restoring divider that forms t one
// quotient bit per stage. Throughput is one ray per cycle unless the
// pipe is full and the output is held by i_out_stall.
//
// Each stage has its own valid bit and advances when it or any stage after
// it has room, so bubbles collapse and a stalled output keeps accepting
// rays until the pipe is full. o_in_stall is high only when all stages hold
// items and the output register is held by i_out_stall.
//
// Reset clears all valid bits and loads the config defaults: center 0,
// normal (0,0,1.0), squared radius 1.0.
module ray_disk_intersection
    import rdi_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_ray                i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_hit                     o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    localparam int unsigned NStage = 41;
    localparam int unsigned DivBase = 4;   // first divider step stage
    localparam int unsigned QBits = 31;

    // ---------------- configuration ----------------
    logic signed [31:0] r_cx, r_cy, r_cz, r_nx, r_ny, r_nz;
    logic [62:0]        r_r2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_cz <= '0;
            r_nx <= '0; r_ny <= '0; r_nz <= NormalZReset;
            r_r2 <= RadiusSquaredReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:       r_cx <= i_cfg_data[31:0];
                CFG_CENTER_Y:       r_cy <= i_cfg_data[31:0];
                CFG_CENTER_Z:       r_cz <= i_cfg_data[31:0];
                CFG_NORMAL_X:       r_nx <= i_cfg_data[31:0];
                CFG_NORMAL_Y:       r_ny <= i_cfg_data[31:0];
                CFG_NORMAL_Z:       r_nz <= i_cfg_data[31:0];
                CFG_RADIUS_SQUARED: r_r2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [NStage-1:0] r_v;
    logic [NStage-1:0] rdy;

    assign rdy[NStage-1] = !r_v[NStage-1] || !i_out_stall;
    for (genvar k = 0; k < NStage - 1; k++) begin : g_rdy
        assign rdy[k] = !r_v[k] || rdy[k+1];
    end

    assign o_in_stall  = !rdy[0];
    assign o_out_valid = r_v[NStage-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_in_valid;
            for (int k = 1; k < NStage; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---------------- S0: origin minus center ----------------
    t_ray               r_ray0;
    logic signed [32:0] r_oc0 [3];

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_ray0   <= i_in_data;
            r_oc0[0] <= 33'(i_in_data.origin_x) - 33'(r_cx);
            r_oc0[1] <= 33'(i_in_data.origin_y) - 33'(r_cy);
            r_oc0[2] <= 33'(i_in_data.origin_z) - 33'(r_cz);
        end
    end

    // ---------------- S1: dot product terms ----------------
    t_ray               r_ray1;
    logic signed [64:0] r_pn1 [3];
    logic signed [63:0] r_pd1 [3];

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_ray1   <= r_ray0;
            r_pn1[0] <= r_oc0[0] * r_nx;
            r_pn1[1] <= r_oc0[1] * r_ny;
            r_pn1[2] <= r_oc0[2] * r_nz;
            r_pd1[0] <= r_ray0.dir_x * r_nx;
            r_pd1[1] <= r_ray0.dir_y * r_ny;
            r_pd1[2] <= r_ray0.dir_z * r_nz;
        end
    end

    // ---------------- S2: num and den sums ----------------
    t_ray               r_ray2;
    logic signed [66:0] r_num2;
    logic signed [65:0] r_den2;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_ray2 <= r_ray1;
            r_num2 <= 67'(r_pn1[0]) + 67'(r_pn1[1]) + 67'(r_pn1[2]);
            r_den2 <= 66'(r_pd1[0]) + 66'(r_pd1[1]) + 66'(r_pd1[2]);
        end
    end

    // ---------------- S3: early reject, divider setup ----------------
    typedef struct packed {
        t_ray              ray;
        logic              rej;
        logic              flip;
        logic              sat;
        logic [96:0]       rem;
        logic [65:0]       b;
        logic [QBits-1:0]  q;
    } t_div;

    t_div r_div [QBits+1];
    t_div n_div [QBits+1];

    logic [66:0] num_mag;
    logic [65:0] den_mag;
    logic [96:0] div_a;
    logic [96:0] div_b31;
    logic [96:0] sh_b [QBits];

    // ---------------- S4..S34: one quotient bit per stage ----------------
    always_comb begin
        num_mag = r_num2[66] ? 67'(-r_num2) : 67'(r_num2);
        den_mag = r_den2[65] ? 66'(-r_den2) : 66'(r_den2);
        div_a   = {14'b0, num_mag, 16'b0};
        div_b31 = {den_mag, 31'b0};

        n_div[0].ray  = r_ray2;
        // parallel ray, start on plane, or plane behind origin
        n_div[0].rej  = (r_den2 == '0) || (r_num2 == '0)
                        || (r_num2[66] == r_den2[65]);
        n_div[0].flip = !r_den2[65];
        n_div[0].sat  = (div_a >= div_b31);
        n_div[0].rem  = div_a;
        n_div[0].b    = den_mag;
        n_div[0].q    = '0;

        for (int j = 0; j < QBits; j++) begin
            sh_b[j]    = {31'b0, r_div[j].b} << (QBits - 1 - j);
            n_div[j+1] = r_div[j];
            if (r_div[j].rem >= sh_b[j]) begin
                n_div[j+1].rem              = r_div[j].rem - sh_b[j];
                n_div[j+1].q[QBits - 1 - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) r_div[0] <= n_div[0];
        for (int j = 0; j < QBits; j++) begin
            if (rdy[DivBase+j]) r_div[j+1] <= n_div[j+1];
        end
    end

    // ---------------- S35: t and t*d ----------------
    t_ray               r_ray35;
    logic               r_rej35, r_flip35;
    logic [30:0]        r_t35;
    logic signed [63:0] r_td35 [3];
    logic [30:0]        t_val;
    logic signed [31:0] t_s;

    always_comb begin
        t_val = r_div[QBits].sat ? DistMax : r_div[QBits].q;
        t_s   = $signed({1'b0, t_val});
    end

    always_ff @(posedge i_clk) begin
        if (rdy[35]) begin
            r_ray35   <= r_div[QBits].ray;
            r_rej35   <= r_div[QBits].rej || (t_val == '0);
            r_flip35  <= r_div[QBits].flip;
            r_t35     <= t_val;
            r_td35[0] <= t_s * r_div[QBits].ray.dir_x;
            r_td35[1] <= t_s * r_div[QBits].ray.dir_y;
            r_td35[2] <= t_s * r_div[QBits].ray.dir_z;
        end
    end

    // ---------------- S36: hit point, floor of t*d ----------------
    logic               r_rej36, r_flip36;
    logic [30:0]        r_t36;
    logic signed [48:0] r_p36 [3];
    logic signed [63:0] td_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) td_sh[i] = r_td35[i] >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[36]) begin
            r_rej36  <= r_rej35;
            r_flip36 <= r_flip35;
            r_t36    <= r_t35;
            r_p36[0] <= 49'(r_ray35.origin_x) + $signed(td_sh[0][48:0]);
            r_p36[1] <= 49'(r_ray35.origin_y) + $signed(td_sh[1][48:0]);
            r_p36[2] <= 49'(r_ray35.origin_z) + $signed(td_sh[2][48:0]);
        end
    end

    // ---------------- S37: |p - c| ----------------
    logic               r_rej37, r_flip37;
    logic [30:0]        r_t37;
    logic signed [48:0] r_p37 [3];
    logic [49:0]        r_dm37 [3];
    logic signed [49:0] diff [3];

    always_comb begin
        diff[0] = 50'(r_p36[0]) - 50'(r_cx);
        diff[1] = 50'(r_p36[1]) - 50'(r_cy);
        diff[2] = 50'(r_p36[2]) - 50'(r_cz);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[37]) begin
            r_rej37  <= r_rej36;
            r_flip37 <= r_flip36;
            r_t37    <= r_t36;
            r_p37    <= r_p36;
            for (int i = 0; i < 3; i++) begin
                r_dm37[i] <= diff[i][49] ? 50'(-diff[i]) : 50'(diff[i]);
            end
        end
    end

    // ---------------- S38: split squares, 25-bit halves ----------------
    logic               r_rej38, r_flip38;
    logic [30:0]        r_t38;
    logic signed [48:0] r_p38 [3];
    logic [49:0]        r_hh38 [3];
    logic [49:0]        r_hl38 [3];
    logic [49:0]        r_ll38 [3];

    always_ff @(posedge i_clk) begin
        if (rdy[38]) begin
            r_rej38  <= r_rej37;
            r_flip38 <= r_flip37;
            r_t38    <= r_t37;
            r_p38    <= r_p37;
            for (int i = 0; i < 3; i++) begin
                r_hh38[i] <= r_dm37[i][49:25] * r_dm37[i][49:25];
                r_hl38[i] <= r_dm37[i][49:25] * r_dm37[i][24:0];
                r_ll38[i] <= r_dm37[i][24:0] * r_dm37[i][24:0];
            end
        end
    end

    // ---------------- S39: per-axis squares ----------------
    logic               r_rej39, r_flip39;
    logic [30:0]        r_t39;
    logic signed [48:0] r_p39 [3];
    logic [99:0]        r_sq39 [3];

    always_ff @(posedge i_clk) begin
        if (rdy[39]) begin
            r_rej39  <= r_rej38;
            r_flip39 <= r_flip38;
            r_t39    <= r_t38;
            r_p39    <= r_p38;
            for (int i = 0; i < 3; i++) begin
                r_sq39[i] <= {r_hh38[i], 50'b0} + {24'b0, r_hl38[i], 26'b0}
                             + {50'b0, r_ll38[i]};
            end
        end
    end

    // ---------------- S40: radius test, output register ----------------
    logic [101:0]       dist_sq;
    logic               hit;
    logic signed [31:0] p_sat [3];

    always_comb begin
        dist_sq = 102'(r_sq39[0]) + 102'(r_sq39[1]) + 102'(r_sq39[2]);
        hit     = !r_rej39 && (dist_sq < {39'b0, r_r2});
        for (int i = 0; i < 3; i++) begin
            if (r_p39[i] > 49'sh0_7FFF_FFFF)
                p_sat[i] = 32'sh7FFF_FFFF;
            else if (r_p39[i] < -49'sh0_8000_0000)
                p_sat[i] = 32'sh8000_0000;
            else
                p_sat[i] = r_p39[i][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[40]) begin
            o_out_data.is_hit   <= hit;
            o_out_data.distance <= hit ? r_t39 : '0;
            o_out_data.point_x  <= hit ? p_sat[0] : '0;
            o_out_data.point_y  <= hit ? p_sat[1] : '0;
            o_out_data.point_z  <= hit ? p_sat[2] : '0;
            o_out_data.flipped  <= hit && r_flip39;
        end
    end

    // ---------------- checks ----------------
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output side free");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_hit) |->
            (o_out_data.distance == '0 && !o_out_data.flipped))
        else $error("miss carries nonzero fields");

    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_hit) |-> (o_out_data.distance != '0))
        else $error("hit with zero distance");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
    import rdi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 400000;
    // Pipe depth is 41 stages; let a bit more than that pass when draining.
    localparam int unsigned DrainCycles = 60;
    localparam int unsigned HoldCycles = 300;
    // Window with no idling on either side.
    localparam int unsigned CalmLo = 2000;
    localparam int unsigned CalmHi = 3500;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_ray                i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_hit                o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    ray_disk_intersection DUT (.*);

    // Disk registers as the block should hold them.
    logic signed [31:0] disk_c[3];
    logic signed [31:0] disk_n[3];
    logic [62:0]        disk_r2;

    t_ray ray_q[$];      // rays waiting to be offered
    t_hit hit_q[$];      // predicted results, oldest first

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned rays_sent = 0;
    int unsigned hits_seen = 0;
    int unsigned results_seen = 0;
    int unsigned stall_seen = 0;
    logic        in_fire = 1'b0;
    logic        hold_go = 1'b0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -128'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Exact-integer disk test: t = -((O-C).n)/(d.n), then radius check.
    function automatic t_hit disk_hit(t_ray r);
        logic signed [127:0] o[3], d[3], c[3], n[3], p[3];
        logic signed [127:0] num, den, anum, aden, dist_sq, diff, tt;
        logic [127:0] q;
        logic [30:0] t;
        t_hit h;
        h = '0;
        o[0] = $signed(r.origin_x); o[1] = $signed(r.origin_y); o[2] = $signed(r.origin_z);
        d[0] = $signed(r.dir_x);    d[1] = $signed(r.dir_y);    d[2] = $signed(r.dir_z);
        num = 0;
        den = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = disk_c[i];
            n[i] = disk_n[i];
            num += (o[i] - c[i]) * n[i];
            den += d[i] * n[i];
        end
        // parallel, on the plane, or behind the origin
        if (den == 0 || num == 0 || ((num < 0) == (den < 0))) return h;
        anum = (num < 0) ? -num : num;
        aden = (den < 0) ? -den : den;
        q = $unsigned(anum <<< 16) / $unsigned(aden);
        t = (q > {97'b0, DistMax}) ? DistMax : q[30:0];
        if (t == 0) return h;
        tt = {97'b0, t};
        dist_sq = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = o[i] + ((tt * d[i]) >>> 16);   // floor toward minus infinity
            diff = p[i] - c[i];
            dist_sq += diff * diff;
        end
        if (!(dist_sq < $signed({65'b0, disk_r2}))) return h;
        h.is_hit = 1'b1;
        h.distance = t;
        h.point_x = clamp32(p[0]);
        h.point_y = clamp32(p[1]);
        h.point_z = clamp32(p[2]);
        h.flipped = (den > 0);
        return h;
    endfunction

    function automatic logic pick_idle();
        if (cycles >= CalmLo && cycles < CalmHi) return 1'b0;
        return $urandom_range(0, 99) < 11;
    endfunction

    // Ray aimed back through the disk center with a random offset.
    function automatic t_ray aimed_ray();
        t_ray r;
        int off[3], sh;
        sh = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++) off[i] = int'($urandom_range(0, 2097152)) - 1048576;
        r.origin_x = disk_c[0] + off[0];
        r.origin_y = disk_c[1] + off[1];
        r.origin_z = disk_c[2] + off[2];
        r.dir_x = -(off[0] >>> sh) + int'($urandom_range(0, 64)) - 32;
        r.dir_y = -(off[1] >>> sh) + int'($urandom_range(0, 64)) - 32;
        r.dir_z = -(off[2] >>> sh) + int'($urandom_range(0, 64)) - 32;
        return r;
    endfunction

    function automatic t_ray noise_ray();
        t_ray r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return r;
    endfunction

    function automatic t_ray mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        t_ray r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [62:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CENTER_X: disk_c[0] = v[31:0];
            CFG_CENTER_Y: disk_c[1] = v[31:0];
            CFG_CENTER_Z: disk_c[2] = v[31:0];
            CFG_NORMAL_X: disk_n[0] = v[31:0];
            CFG_NORMAL_Y: disk_n[1] = v[31:0];
            CFG_NORMAL_Z: disk_n[2] = v[31:0];
            CFG_RADIUS_SQUARED: disk_r2 = v;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_disk(int cx, int cy, int cz, int nx, int ny, int nz, logic [62:0] r2);
        write_reg(CFG_CENTER_X, {{31{cx[31]}}, cx});
        write_reg(CFG_CENTER_Y, {{31{cy[31]}}, cy});
        write_reg(CFG_CENTER_Z, {{31{cz[31]}}, cz});
        write_reg(CFG_NORMAL_X, {{31{nx[31]}}, nx});
        write_reg(CFG_NORMAL_Y, {{31{ny[31]}}, ny});
        write_reg(CFG_NORMAL_Z, {{31{nz[31]}}, nz});
        write_reg(CFG_RADIUS_SQUARED, r2);
    endtask

    // Wait until every offered item has come back, then let the pipe drain.
    task automatic drain();
        while (ray_q.size() != 0 || i_in_valid || hit_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic random_rays(int unsigned count);
        @(posedge i_clk);
        for (int unsigned k = 0; k < count; k++)
            ray_q.push_back(($urandom_range(0, 3) == 0) ? noise_ray() : aimed_ray());
    endtask

    // Sender: next item at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (ray_q.size() != 0 && !pick_idle()) begin
                i_in_data <= ray_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to fill the pipe.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_go && !hold_done && hold_left == 0) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= (hold_left != 1);
        end else begin
            i_out_stall <= pick_idle();
        end
    end

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %h, got %h", name, exp, act);
            errors++;
        end
    endtask

    // Predict on input acceptance, check on output acceptance.
    always @(posedge i_clk) begin
        t_hit e;
        cycles <= cycles + 1;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) stall_seen++;
            if (i_in_valid && !o_in_stall) begin
                hit_q.push_back(disk_hit(i_in_data));
                rays_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (hit_q.size() == 0) begin
                    $error("result item with nothing expected");
                    errors++;
                end else begin
                    e = hit_q.pop_front();
                    if (e.is_hit) hits_seen++;
                    check_field("is_hit", 32'(e.is_hit), 32'(o_out_data.is_hit));
                    check_field("distance", 32'(e.distance), 32'(o_out_data.distance));
                    check_field("point_x", e.point_x, o_out_data.point_x);
                    check_field("point_y", e.point_y, o_out_data.point_y);
                    check_field("point_z", e.point_z, o_out_data.point_z);
                    check_field("flipped", 32'(e.flipped), 32'(o_out_data.flipped));
                end
            end
        end
        if (cycles > CycleLimit) begin
            $display("[ray_disk_intersection] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        disk_c = '{0, 0, 0};
        disk_n = '{0, 0, NormalZReset};
        disk_r2 = RadiusSquaredReset;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rays against the reset disk: unit radius in z = 0.
        @(posedge i_clk);
        ray_q.push_back(mk_ray(0, 0, 65536, 0, 0, -65536));        // straight hit at center
        ray_q.push_back(mk_ray(0, 0, -65536, 0, 0, 65536));        // hit from below, flipped
        ray_q.push_back(mk_ray(0, 0, 65536, 65536, 0, 0));         // parallel to plane
        ray_q.push_back(mk_ray(0, 0, 65536, 0, 0, 65536));         // pointing away
        ray_q.push_back(mk_ray(30000, 0, 0, 0, 0, -65536));        // origin on the plane
        ray_q.push_back(mk_ray(0, 0, 1, 0, 0, -32'sh7FFF_FFFF));   // t truncates to zero
        ray_q.push_back(mk_ray(0, 0, 32'sh7FFF_FFFF, 0, 0, -1));   // t saturates
        ray_q.push_back(mk_ray(65536, 0, 65536, 0, 0, -65536));    // on the rim, miss
        ray_q.push_back(mk_ray(65535, 0, 65536, 0, 0, -65536));    // just inside rim
        ray_q.push_back(mk_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        ray_q.push_back(mk_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        ray_q.push_back(mk_ray(-1, -1, -1, -1, -1, -1));
        ray_q.push_back(mk_ray(0, 0, 0, 0, 0, 0));
        ray_q.push_back(mk_ray(1000, -1000, 131072, -500, 500, -65536));
        drain();

        // Huge disk so saturated t and out-of-range points still hit.
        set_disk(0, 0, 0, 0, 0, 65536, 63'h7FFF_FFFF_FFFF_FFFF);
        @(posedge i_clk);
        ray_q.push_back(mk_ray(0, 0, 32'sh7FFF_FFFF, 0, 0, -1));
        ray_q.push_back(mk_ray(32'sh7000_0000, 0, 65536, 32'sh7000_0000, 0, -1));
        ray_q.push_back(mk_ray(32'sh9000_0000, 0, -65536, 32'sh9000_0000, 0, 1));
        ray_q.push_back(mk_ray(5, 7, 3, 1, -1, -1));
        drain();

        random_rays(350);
        drain();

        // Tilted disk with a random modest size; long receiver hold-off here.
        set_disk(int'($urandom_range(0, 33554432)) - 16777216,
                 int'($urandom_range(0, 33554432)) - 16777216,
                 int'($urandom_range(0, 33554432)) - 16777216,
                 int'($urandom_range(0, 262144)) - 131072,
                 int'($urandom_range(0, 262144)) - 131072,
                 int'($urandom_range(0, 262144)) - 131072,
                 {23'b0, 8'($urandom_range(0, 255)), 32'h0} | 63'(40'hFF_FFFF_FFFF));
        @(posedge i_clk);
        hold_go <= 1'b1;
        random_rays(450);
        drain();

        // Extreme corners of the register ranges.
        set_disk(32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
        random_rays(300);
        drain();

        // Zero radius and zero normal: nothing can hit.
        set_disk(0, 0, 0, 0, 0, 0, 63'h0);
        random_rays(100);
        drain();

        set_disk(int'($urandom), int'($urandom), int'($urandom),
                 int'($urandom_range(0, 131072)) - 65536, 65536, -65536,
                 63'({$urandom, $urandom} >> 1));
        random_rays(300);
        drain();

        $display("rays %0d, results %0d, hits %0d, input stall cycles %0d",
                 rays_sent, results_seen, hits_seen, stall_seen);
        $display("disks: reset, huge, tilted, extreme, degenerate, random");
        if (errors == 0 && hit_q.size() == 0) begin
            $display("[ray_disk_intersection] OK");
        end else begin
            $display("[ray_disk_intersection] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
